FILE: rtl/rer_pkg.sv
package rer_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int PIX_W       = 8;
    localparam int ROW_W       = 8;
    localparam int STEP        = 3;
    localparam int CFG_W       = 9;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;

    localparam logic REG_THRESHOLD    = 1'b0;
    localparam logic REG_ACTIVE_WIDTH = 1'b1;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] WIDTH_RESET     = CFG_W'(256);
    localparam logic [CFG_W-1:0] WIDTH_MAX       = CFG_W'(MAX_COLUMNS);

endpackage

FILE: rtl/row_edge_ratio_search.sv
// Row edge search by difference over sum. Load items (mode 0) write one grey
// pixel into a 256-entry line buffer and are taken one per cycle while no
// search runs. A search item (mode 1 leftward, mode 2 rightward) walks the row
// from its start column in steps of 3, comparing each pixel a with the pixel
// b four columns further on, and stops at the first column where
// |a-b|*256 > ratio_threshold*(a+b). The line buffer's one read port sets the
// pace: each column checked reads a, reads b, then multiplies and compares; a
// search ends by waiting for the output register to free, and no item is
// taken meanwhile. The result carries the column found (else the last column
// checked, else 0), the row (0 if none was checked) and a found flag; it
// waits in an output register so loads may continue.
// Rightward scans are bounded by active_width, clamped to 256. Every column a
// search reads must have been loaded since reset.
module row_edge_ratio_search
    import rer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // column, pixel, row
    input  logic [1:0]            s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // edge_column, edge_row
    output logic                  m_tuser,   // edge_found
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHECK   = 3'd1;
    localparam logic [2:0] ST_READ_B  = 3'd2;
    localparam logic [2:0] ST_COMPARE = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] thr_reg, thr_next;
    logic [CFG_W-1:0] width_reg, width_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             left_reg, left_next;
    logic [COL_W-1:0] fcol_reg, fcol_next;
    logic [ROW_W-1:0] frow_reg, frow_next;
    logic             found_reg, found_next;
    logic [PIX_W-1:0] a_reg, a_next;
    logic             ovalid_reg, ovalid_next;
    logic [15:0]      odata_reg, odata_next;
    logic             ofound_reg, ofound_next;

    logic [1:0]        in_mode;
    logic [COL_W-1:0]  in_col;
    logic [PIX_W-1:0]  in_pix;
    logic [ROW_W-1:0]  in_row;
    logic              in_acc;
    logic              cfg_wr;
    logic [CFG_W-1:0]  width_eff;
    logic              in_range;
    logic [COL_W-1:0]  partner;
    logic [COL_W-1:0]  rd_addr;
    logic              rd_en;
    logic [PIX_W-1:0]  rd_data;
    logic [PIX_W-1:0]  diff;
    logic [PIX_W:0]    sum;
    logic [2*CFG_W-1:0] prod;
    logic              hit;

    assign in_col  = s_tdata[COL_W-1:0];
    assign in_pix  = s_tdata[COL_W+PIX_W-1:COL_W];
    assign in_row  = s_tdata[COL_W+PIX_W+ROW_W-1:COL_W+PIX_W];
    assign in_mode = s_tuser;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ACTIVE_WIDTH)
                  ? {{(APB_DATA_W-CFG_W){1'b0}}, width_reg}
                  : {{(APB_DATA_W-CFG_W){1'b0}}, thr_reg};

    assign width_eff = (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
    assign in_range  = left_reg
                     ? (col_reg > COL_W'(STEP + 1))
                     : ((10'(col_reg) + 10'(STEP + 1)) < 10'(width_eff));
    assign partner   = left_reg ? (col_reg - COL_W'(STEP + 1))
                                : (col_reg + COL_W'(STEP + 1));

    assign rd_en   = (state_reg == ST_CHECK) || (state_reg == ST_READ_B);
    assign rd_addr = (state_reg == ST_READ_B) ? partner : col_reg;

    rer_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (in_acc && (in_mode == MODE_LOAD)),
        .wr_addr (in_col),
        .wr_data (in_pix),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign diff = (a_reg > rd_data) ? (a_reg - rd_data) : (rd_data - a_reg);
    assign sum  = {1'b0, a_reg} + {1'b0, rd_data};
    assign prod = (2*CFG_W)'(thr_reg) * (2*CFG_W)'(sum);
    assign hit  = (sum != '0)
               && ({{(2*CFG_W-2*PIX_W){1'b0}}, diff, {PIX_W{1'b0}}} > prod);

    always_comb
    begin
        state_next  = state_reg;
        thr_next    = thr_reg;
        width_next  = width_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        fcol_next   = fcol_reg;
        frow_next   = frow_reg;
        found_next  = found_reg;
        a_next      = a_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        ofound_next = ofound_reg;

        if (cfg_wr)
        begin
            case (paddr[2])
                REG_THRESHOLD:    thr_next   = pwdata[CFG_W-1:0];
                REG_ACTIVE_WIDTH: width_next = pwdata[CFG_W-1:0];
                default:          thr_next   = thr_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && ((in_mode == MODE_LEFT) || (in_mode == MODE_RIGHT)))
                begin
                    col_next   = in_col;
                    row_next   = in_row;
                    left_next  = (in_mode == MODE_LEFT);
                    fcol_next  = '0;
                    frow_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (in_range)
                begin
                    fcol_next  = col_reg;
                    frow_next  = row_reg;
                    state_next = ST_READ_B;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_B:
            begin
                a_next     = rd_data;
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    col_next   = left_reg ? (col_reg - COL_W'(STEP))
                                          : (col_reg + COL_W'(STEP));
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {frow_reg, fcol_reg};
                    ofound_next = found_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            thr_reg    <= THRESHOLD_RESET;
            width_reg  <= WIDTH_RESET;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            thr_reg    <= thr_next;
            width_reg  <= width_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        left_reg   <= left_next;
        fcol_reg   <= fcol_next;
        frow_reg   <= frow_next;
        a_reg      <= a_next;
        odata_reg  <= odata_next;
        ofound_reg <= ofound_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ofound_reg;

endmodule

FILE: rtl/rer_ram.sv
module rer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: bench/tb_row_edge_ratio_search.sv
`timescale 1ns / 1ps

module tb_row_edge_ratio_search;
    import rer_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int GAP_MAX   = 17;
    localparam int SETTLE    = 12;
    localparam int TAIL_WAIT = 300;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic       found;
    } edge_hit_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] col;
        logic [7:0] pix;
        logic [7:0] row;
        logic       typed;
        edge_hit_t  hit;
    } probe_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;   // column, pixel, row
    logic [1:0]            s_tuser;   // mode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // edge_column, edge_row
    logic                  m_tuser;   // edge_found
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [PIX_W-1:0] row_pixels [MAX_COLUMNS];
    logic [CFG_W-1:0] cur_thresh;
    logic [CFG_W-1:0] cur_width;
    edge_hit_t        pending_hits [$];
    probe_t           probe_list [$];
    int               fault_count;
    bit               tx_calm;
    bit               rx_calm;

    row_edge_ratio_search DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #(40_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit ratio_hit(int a, int b);
        int diff;
        int sum;
        sum  = a + b;
        diff = (a > b) ? a - b : b - a;
        if (sum == 0)
            return 1'b0;
        return (diff * 256) > (int'(cur_thresh) * sum);
    endfunction

    function automatic edge_hit_t scan_row(logic [1:0] mode, int start, logic [7:0] row);
        edge_hit_t res;
        int        lim;
        int        c;
        res = '0;
        if (mode == MODE_LEFT)
        begin
            for (c = start; c > STEP + 1; c -= STEP)
            begin
                res.col = c[7:0];
                res.row = row;
                if (ratio_hit(row_pixels[c], row_pixels[c - STEP - 1]))
                begin
                    res.found = 1'b1;
                    break;
                end
            end
        end
        else
        begin
            lim = (int'(cur_width) > MAX_COLUMNS) ? MAX_COLUMNS : int'(cur_width);
            for (c = start; c < lim - STEP - 1; c += STEP)
            begin
                res.col = c[7:0];
                res.row = row;
                if (ratio_hit(row_pixels[c], row_pixels[c + STEP + 1]))
                begin
                    res.found = 1'b1;
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic send_item(logic [1:0] mode, logic [7:0] col, logic [7:0] pix,
                             logic [7:0] row, logic typed, edge_hit_t typed_hit);
        int        gap;
        edge_hit_t exp_hit;
        gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, pix, col};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        if (mode == MODE_LOAD)
            row_pixels[col] = pix;
        else if (mode == MODE_LEFT || mode == MODE_RIGHT)
        begin
            exp_hit      = typed ? typed_hit : scan_row(mode, col, row);
            pending_hits = {pending_hits, exp_hit};
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(logic reg_idx, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(reg_idx));
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_THRESHOLD)
            cur_thresh = value;
        else
            cur_width = value;
    endtask

    function automatic void add_probe(logic [1:0] mode, logic [7:0] col, logic [7:0] pix,
                                      logic [7:0] row, logic typed, logic [7:0] hcol,
                                      logic [7:0] hrow, logic hfound);
        probe_t entry;
        entry      = '{mode, col, pix, row, typed, '{hcol, hrow, hfound}};
        probe_list = {probe_list, entry};
    endfunction

    task automatic random_phase(int n_items);
        int        sent;
        int        kind;
        int        base;
        int        span;
        int        lvl;
        int        lvl2;
        int        nz;
        int        k;
        int        v;
        int        n_search;
        int        start;
        int        pick;
        logic [1:0] mode;
        sent = 0;
        while (sent < n_items)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 3);
            base = $urandom_range(0, MAX_COLUMNS - 1);
            span = $urandom_range(4, 40);
            lvl  = $urandom_range(0, 255);
            lvl2 = $urandom_range(0, 255);
            nz   = $urandom_range(0, 24);
            for (k = 0; k < span && base + k < MAX_COLUMNS; k++)
            begin
                case (kind)
                    0: v = $urandom_range(0, 255);
                    1: v = lvl + $urandom_range(0, 2 * nz) - nz;
                    2: v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
                    default: v = (k < span / 2) ? lvl : lvl2;
                endcase
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                send_item(MODE_LOAD, 8'(base + k), 8'(v), 8'($urandom_range(0, 255)),
                          1'b0, '0);
                sent++;
            end
            n_search = $urandom_range(1, 4);
            repeat (n_search)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    mode = MODE_SPARE;
                else if (pick < 10)
                    mode = MODE_LEFT;
                else
                    mode = MODE_RIGHT;
                if ($urandom_range(0, 1) == 0)
                    start = base + $urandom_range(0, span);
                else
                    start = $urandom_range(0, MAX_COLUMNS - 1);
                if (start > MAX_COLUMNS - 1)
                    start = MAX_COLUMNS - 1;
                send_item(mode, 8'(start), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // result sink: stall a random number of cycles before each item
    initial
    begin : sink
        int stall;
        m_tready = 1'b0;
        rx_calm  = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : result_check
        edge_hit_t want;
        edge_hit_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[7:0], m_tdata[15:8], m_tuser};
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected result col=%0d row=%0d found=%0b",
                         $time, got.col, got.row, got.found);
                fault_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got.col !== want.col)
                begin
                    $display("%0t: edge_column expected %0d actual %0d",
                             $time, want.col, got.col);
                    fault_count++;
                end
                if (got.row !== want.row)
                begin
                    $display("%0t: edge_row expected %0d actual %0d",
                             $time, want.row, got.row);
                    fault_count++;
                end
                if (got.found !== want.found)
                begin
                    $display("%0t: edge_found expected %0b actual %0b",
                             $time, want.found, got.found);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int         c;
        int         p;
        int         t;
        logic [8:0] thresh_set [9];
        logic [8:0] width_set [9];
        probe_t     pr;
        thresh_set = '{9'd0, 9'd256, 9'd511, 9'd64, 9'd1, 9'd128, 9'd255, 9'd32, 9'd0};
        width_set  = '{9'd256, 9'd8, 9'd511, 9'd0, 9'd9, 9'd300, 9'd128, 9'd257, 9'd0};
        thresh_set[8] = 9'($urandom_range(0, 511));
        width_set[8]  = 9'($urandom_range(0, 511));
        fault_count = 0;
        tx_calm     = 1'b0;
        cur_thresh  = THRESHOLD_RESET;
        cur_width   = WIDTH_RESET;
        for (c = 0; c < MAX_COLUMNS; c++)
            row_pixels[c] = '0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_LOAD;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole row flat so no search reads an unwritten pixel
        for (c = 0; c < MAX_COLUMNS; c++)
            send_item(MODE_LOAD, 8'(c), 8'd100, 8'(c), 1'b0, '0);

        add_probe(MODE_LEFT,  8'd4,   8'd0,   8'd7,   1'b1, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_LEFT,  8'd255, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_RIGHT, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_RIGHT, 8'd252, 8'd0,   8'd9,   1'b1, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_SPARE, 8'd9,   8'd9,   8'd9,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_LOAD,  8'd20,  8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_LOAD,  8'd24,  8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_RIGHT, 8'd20,  8'd0,   8'd1,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_LOAD,  8'd30,  8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_LOAD,  8'd34,  8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_RIGHT, 8'd30,  8'd0,   8'hAA,  1'b1, 8'd30,  8'hAA,  1'b1);
        add_probe(MODE_LEFT,  8'd34,  8'd0,   8'h55,  1'b1, 8'd34,  8'h55,  1'b1);
        add_probe(MODE_LOAD,  8'd255, 8'd255, 8'hFF,  1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_LOAD,  8'd251, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_LEFT,  8'd255, 8'd0,   8'h80,  1'b1, 8'd255, 8'h80,  1'b1);
        add_probe(MODE_RIGHT, 8'd251, 8'd0,   8'h01,  1'b1, 8'd251, 8'h01,  1'b1);
        add_probe(MODE_LEFT,  8'd5,   8'd0,   8'd3,   1'b0, 8'd0,   8'd0,   1'b0);
        add_probe(MODE_LEFT,  8'd22,  8'd0,   8'd64,  1'b0, 8'd0,   8'd0,   1'b0);
        for (p = 0; p < probe_list.size(); p++)
        begin
            pr = probe_list[p];
            send_item(pr.mode, pr.col, pr.pix, pr.row, pr.typed, pr.hit);
        end

        for (t = 0; t < 9; t++)
        begin
            // hold the sender until every search has answered
            settle();
            cfg_write(REG_THRESHOLD, thresh_set[t]);
            cfg_write(REG_ACTIVE_WIDTH, width_set[t]);
            rx_calm = (t % 3 == 1);
            random_phase(150);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (fault_count == 0 && pending_hits.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/rer_pkg.sv
rtl/rer_ram.sv
rtl/row_edge_ratio_search.sv
bench/tb_row_edge_ratio_search.sv
